/* rtl/tbc_pkg.sv */
// shared types and constants of the three-bit processor step block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tbc_pkg;

	localparam int PROG_DEPTH_DEF = 64;
	localparam int DATA_W = 64;
	localparam int LEN_W = 7;
	localparam int WORD_W = 3;
	localparam int CFG_IDX_W = 2;

	// command kinds on the input stream
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_EXEC    = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INIT_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_C = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROG_LEN = 2'd3;

	// instruction opcodes
	localparam logic [WORD_W-1:0] OP_ADV = 3'd0;
	localparam logic [WORD_W-1:0] OP_BXL = 3'd1;
	localparam logic [WORD_W-1:0] OP_BST = 3'd2;
	localparam logic [WORD_W-1:0] OP_JNZ = 3'd3;
	localparam logic [WORD_W-1:0] OP_BXC = 3'd4;
	localparam logic [WORD_W-1:0] OP_OUT = 3'd5;
	localparam logic [WORD_W-1:0] OP_BDV = 3'd6;
	localparam logic [WORD_W-1:0] OP_CDV = 3'd7;

	// combo operand selectors
	localparam logic [WORD_W-1:0] ARG_REG_A = 3'd4;
	localparam logic [WORD_W-1:0] ARG_REG_B = 3'd5;
	localparam logic [WORD_W-1:0] ARG_REG_C = 3'd6;
	localparam logic [WORD_W-1:0] ARG_RSVD = 3'd7;

	// outcome of one executed instruction
	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] c;
		logic              jump;
		logic              emitted;
		logic [WORD_W-1:0] emit_val;
		logic              bad;
	} exec_res_t;

endpackage

`default_nettype wire

/* rtl/tbc_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tbc_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/tbc_exec.sv */
// execute unit: decodes one opcode/operand pair against registers a, b, c
// depends on tbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tbc_exec (
	input  logic [tbc_pkg::WORD_W-1:0] op,
	input  logic [tbc_pkg::WORD_W-1:0] arg,
	input  logic [tbc_pkg::DATA_W-1:0] a,
	input  logic [tbc_pkg::DATA_W-1:0] b,
	input  logic [tbc_pkg::DATA_W-1:0] c,
	output tbc_pkg::exec_res_t         res
);
	import tbc_pkg::*;

	logic [DATA_W-1:0] combo;
	logic              uses_combo;
	logic [DATA_W-1:0] a_shr;

	always_comb begin
		case (arg)
			ARG_REG_A: combo = a;
			ARG_REG_B: combo = b;
			ARG_REG_C: combo = c;
			default:   combo = DATA_W'(arg);
		endcase
	end

	// shift by 64 or more clears
	assign a_shr = (combo[DATA_W-1:6] != '0) ? '0 : (a >> combo[5:0]);

	assign uses_combo = (op == OP_ADV) || (op == OP_BST) || (op == OP_OUT) ||
		(op == OP_BDV) || (op == OP_CDV);

	always_comb begin
		res = '{a: a, b: b, c: c, jump: 1'b0, emitted: 1'b0, emit_val: '0, bad: 1'b0};
		if (uses_combo && arg == ARG_RSVD) begin
			res.bad = 1'b1;
		end else begin
			unique case (op)
				OP_ADV: res.a = a_shr;
				OP_BXL: res.b = b ^ DATA_W'(arg);
				OP_BST: res.b = DATA_W'(combo[WORD_W-1:0]);
				OP_JNZ: res.jump = (a != '0);
				OP_BXC: res.b = b ^ c;
				OP_OUT: begin
					res.emitted = 1'b1;
					res.emit_val = combo[WORD_W-1:0];
				end
				OP_BDV: res.b = a_shr;
				OP_CDV: res.c = a_shr;
				default: res.bad = 1'b0;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/three_bit_cpu_step.sv */
// three_bit_cpu_step: one command per beat, result valid in the cycle after the input beat
// throughput one command per cycle unless the result stream stalls; program words sit
// in two ram copies read at pc and pc+1, addressed by the next pc so the pair is ready
// when the next beat comes; a load that hits the word being fetched is forwarded from
// a bypass register; async reset clears registers a, b, c, the counter and the
// configuration; program memory is not cleared and holds garbage until loaded
`timescale 1ns / 1ps
`default_nettype none

module three_bit_cpu_step #(
	parameter int PROG_DEPTH = tbc_pkg::PROG_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // word_index[5:0], word_value[8:6], zero pad
	input  logic [1:0]                    s_tuser,   // opcode[1:0]
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // emitted[0], emitted_value[3:1],
	                                                 // halted[4], bad_operand[5], zero pad
	// configuration writes
	input  logic                          cfg_we,
	input  logic [tbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tbc_pkg::DATA_W-1:0]    cfg_data
);
	import tbc_pkg::*;

	localparam int AW = $clog2(PROG_DEPTH);
	// counter must hold a jump target up to seven and pc+2 up to the depth
	localparam int PC_MAX = (PROG_DEPTH > 7) ? PROG_DEPTH : 7;
	localparam int PCW = $clog2(PC_MAX + 1);
	localparam int CMPW = ((PCW > LEN_W) ? PCW : LEN_W) + 1;

	// configuration
	logic [DATA_W-1:0] init_a_q, init_b_q, init_c_q;
	logic [LEN_W-1:0]  prog_len_q;

	// architectural state
	logic [DATA_W-1:0] reg_a_q, reg_b_q, reg_c_q;
	logic [PCW-1:0]    pc_q, pc_d;

	// input beat decode
	cmd_t              cmd;
	logic [5:0]        word_index;
	logic [WORD_W-1:0] word_value;
	logic              acc;

	// fetch
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     ra_op, ra_arg;
	logic [WORD_W-1:0] rd_op, rd_arg;
	logic              fwd_op_q, fwd_arg_q;
	logic [WORD_W-1:0] fwd_data_q;
	logic [WORD_W-1:0] op, arg;

	// execute
	exec_res_t         res;
	logic [CMPW-1:0]   eff_len;
	logic              halted_now, halted_nx;
	logic              exec_go;

	// output register
	logic              m_valid_q;
	logic [7:0]        m_data_q;

	assign cmd = cmd_t'(s_tuser);
	assign word_index = s_tdata[5:0];
	assign word_value = s_tdata[8:6];

	// output register frees the input side whenever it drains
	assign s_tready = !m_valid_q || m_tready;
	assign acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_a_q <= '0;
			init_b_q <= '0;
			init_c_q <= '0;
			prog_len_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INIT_A:   init_a_q <= cfg_data;
				REG_INIT_B:   init_b_q <= cfg_data;
				REG_INIT_C:   init_c_q <= cfg_data;
				REG_PROG_LEN: prog_len_q <= cfg_data[LEN_W-1:0];
				default:      prog_len_q <= prog_len_q;
			endcase
		end
	end

	// program length saturates at the memory depth
	assign eff_len = (32'(prog_len_q) > 32'(PROG_DEPTH)) ? CMPW'(PROG_DEPTH) : CMPW'(prog_len_q);

	// halted when no full opcode/operand pair is left
	assign halted_now = (CMPW'(pc_q) + CMPW'(1)) >= eff_len;
	assign halted_nx = (CMPW'(pc_d) + CMPW'(1)) >= eff_len;

	// loads past the memory end are dropped
	assign mem_we = acc && (cmd == CMD_LOAD) && (32'(word_index) < 32'(PROG_DEPTH));
	assign mem_waddr = AW'(word_index);

	// fetch addresses follow the next pc
	assign ra_op = pc_d[AW-1:0];
	assign ra_arg = AW'(pc_d + PCW'(1));

	tbc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(PROG_DEPTH)
	) u_ram_op (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(word_value),
		.raddr(ra_op),
		.rdata(rd_op)
	);

	tbc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(PROG_DEPTH)
	) u_ram_arg (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(word_value),
		.raddr(ra_arg),
		.rdata(rd_arg)
	);

	// bypass a load that lands on a word being fetched this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_op_q <= 1'b0;
			fwd_arg_q <= 1'b0;
		end else begin
			fwd_op_q <= mem_we && (mem_waddr == ra_op);
			fwd_arg_q <= mem_we && (mem_waddr == ra_arg);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= word_value;
	end

	assign op = fwd_op_q ? fwd_data_q : rd_op;
	assign arg = fwd_arg_q ? fwd_data_q : rd_arg;

	tbc_exec u_exec (
		.op(op),
		.arg(arg),
		.a(reg_a_q),
		.b(reg_b_q),
		.c(reg_c_q),
		.res(res)
	);

	assign exec_go = acc && (cmd == CMD_EXEC) && !halted_now;

	// next program counter
	always_comb begin
		pc_d = pc_q;
		if (acc && cmd == CMD_RESTART) begin
			pc_d = '0;
		end else if (exec_go) begin
			pc_d = res.jump ? PCW'(arg) : pc_q + PCW'(2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_a_q <= '0;
			reg_b_q <= '0;
			reg_c_q <= '0;
			pc_q <= '0;
		end else begin
			pc_q <= pc_d;
			if (acc && cmd == CMD_RESTART) begin
				reg_a_q <= init_a_q;
				reg_b_q <= init_b_q;
				reg_c_q <= init_c_q;
			end else if (exec_go) begin
				reg_a_q <= res.a;
				reg_b_q <= res.b;
				reg_c_q <= res.c;
			end
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (acc) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			m_data_q <= {2'b00,
				exec_go && res.bad,
				halted_nx,
				exec_go ? res.emit_val : 3'b000,
				exec_go && res.emitted};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	// restart never reports output or a fault
	a_restart_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd == CMD_RESTART |=> m_tvalid && !m_tdata[0] && !m_tdata[5])
		else $error("restart beat reported output or fault");

	// a non-jumping executed step advances the counter by two
	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go && !res.jump |=> pc_q == $past(pc_q) + PCW'(2))
		else $error("program counter did not advance by two");

	// loads leave registers a and b and the counter untouched
	a_load_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd == CMD_LOAD |=> $stable(reg_a_q) && $stable(reg_b_q) && $stable(pc_q))
		else $error("load changed architectural state");

	// a halted execute keeps the counter, emits nothing and reports halted
	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd == CMD_EXEC && halted_now |=> $stable(pc_q) && m_tdata[4] && !m_tdata[0])
		else $error("halted execute changed state");

endmodule

`default_nettype wire

/* dv/cpu_step_checker.sv */
`timescale 1ns / 1ps
// status checker for three_bit_cpu_step: mirrors the processor state, predicts the
// status beat of every command and compares it with the result stream; uses tbc_pkg

module cpu_step_checker #(
	parameter int PROG_DEPTH = tbc_pkg::PROG_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // word_index[5:0], word_value[8:6], zero pad
	input  logic [1:0]                    s_tuser,   // opcode[1:0]
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [7:0]                    m_tdata,   // emitted[0], emitted_value[3:1],
	                                                 // halted[4], bad_operand[5], zero pad
	input  logic                          cfg_we,
	input  logic [tbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tbc_pkg::DATA_W-1:0]    cfg_data,
	output int                            errors,
	output int                            pending
);
	import tbc_pkg::*;

	// same bit order as m_tdata[5:0]
	typedef struct packed {
		logic              bad;
		logic              halted;
		logic [WORD_W-1:0] value;
		logic              emitted;
	} status_t;

	logic [WORD_W-1:0] words [PROG_DEPTH];
	logic [DATA_W-1:0] reg_a_q, reg_b_q, reg_c_q;
	logic [DATA_W-1:0] init_a_q, init_b_q, init_c_q;
	logic [LEN_W-1:0]  len_q;
	int                pc_q;
	int                beat_no;
	status_t           status_q [$];

	function automatic logic halted_now();
		int eff;
		eff = (int'(len_q) > PROG_DEPTH) ? PROG_DEPTH : int'(len_q);
		return (pc_q + 1 >= eff);
	endfunction

	// shifts of the full width or more clear the value
	function automatic logic [DATA_W-1:0] shift_down(input logic [DATA_W-1:0] v,
			input logic [DATA_W-1:0] n);
		return (n >= DATA_W) ? '0 : (v >> n);
	endfunction

	function automatic logic [DATA_W-1:0] combo(input logic [WORD_W-1:0] sel);
		case (sel)
			ARG_REG_A: return reg_a_q;
			ARG_REG_B: return reg_b_q;
			ARG_REG_C: return reg_c_q;
			default:   return DATA_W'(sel);
		endcase
	endfunction

	task automatic step_cpu(input cmd_t kind, input logic [5:0] idx,
			input logic [WORD_W-1:0] val, output status_t res);
		logic [WORD_W-1:0] op;
		logic [WORD_W-1:0] arg;
		logic [DATA_W-1:0] operand;
		logic              takes_combo;
		res = '0;
		case (kind)
			CMD_LOAD: begin
				if (int'(idx) < PROG_DEPTH)
					words[idx] = val;
			end
			CMD_RESTART: begin
				reg_a_q = init_a_q;
				reg_b_q = init_b_q;
				reg_c_q = init_c_q;
				pc_q = 0;
			end
			CMD_EXEC: begin
				if (!halted_now()) begin
					op = words[pc_q];
					arg = words[pc_q + 1];
					takes_combo = !(op == OP_BXL || op == OP_JNZ || op == OP_BXC);
					operand = combo(arg);
					if (takes_combo && arg == ARG_RSVD) begin
						// reserved operand: flag it and skip the pair
						res.bad = 1'b1;
						pc_q += 2;
					end else begin
						case (op)
							OP_ADV: reg_a_q = shift_down(reg_a_q, operand);
							OP_BXL: reg_b_q ^= DATA_W'(arg);
							OP_BST: reg_b_q = DATA_W'(operand[WORD_W-1:0]);
							OP_BXC: reg_b_q ^= reg_c_q;
							OP_OUT: begin
								res.emitted = 1'b1;
								res.value = operand[WORD_W-1:0];
							end
							OP_BDV: reg_b_q = shift_down(reg_a_q, operand);
							OP_CDV: reg_c_q = shift_down(reg_a_q, operand);
							default: ;
						endcase
						if (op == OP_JNZ && reg_a_q != '0)
							pc_q = int'(arg);
						else
							pc_q += 2;
					end
				end
			end
			default: ;
		endcase
		res.halted = halted_now();
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: status beat %0d, %s expected %0d actual %0d",
				$time, beat_no, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_t want;
		status_t got;
		if (!arst_n) begin
			reg_a_q = '0;
			reg_b_q = '0;
			reg_c_q = '0;
			init_a_q = '0;
			init_b_q = '0;
			init_c_q = '0;
			len_q = '0;
			pc_q = 0;
			beat_no = 0;
			errors = 0;
			pending = 0;
			status_q.delete();
			for (int i = 0; i < PROG_DEPTH; i++)
				words[i] = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INIT_A:   init_a_q = cfg_data;
					REG_INIT_B:   init_b_q = cfg_data;
					REG_INIT_C:   init_c_q = cfg_data;
					REG_PROG_LEN: len_q = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				step_cpu(cmd_t'(s_tuser), s_tdata[5:0], s_tdata[8:6], want);
				status_q.insert(status_q.size(), want);
			end
			if (m_tvalid && m_tready) begin
				got = status_t'(m_tdata[5:0]);
				if (status_q.size() == 0) begin
					errors++;
					$display("%0t: status beat %0d with nothing expected, actual %h",
						$time, beat_no, m_tdata);
				end else begin
					want = status_q.pop_front();
					check_field("emitted", want.emitted, got.emitted);
					check_field("emitted_value", want.value, got.value);
					check_field("halted", want.halted, got.halted);
					check_field("bad_operand", want.bad, got.bad);
				end
				beat_no++;
			end
			pending = status_q.size();
		end
	end

endmodule

/* dv/tb_three_bit_cpu_step.sv */
`timescale 1ns / 1ps
// testbench top for three_bit_cpu_step: clock, reset, command stimulus and verdict
// depends on tbc_pkg, three_bit_cpu_step and cpu_step_checker

module tb_three_bit_cpu_step;
	import tbc_pkg::*;

	localparam int TARGET_ITEMS = 1550;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [DATA_W-1:0] ALL_ONES = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;     // word_index[5:0], word_value[8:6], zero pad
	logic [1:0]           s_tuser = '0;     // opcode[1:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;          // emitted[0], emitted_value[3:1],
	                                        // halted[4], bad_operand[5], zero pad
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;
	int                   errors;
	int                   pending;

	// program image that the next phase loads, one 3-bit word per entry
	logic [WORD_W-1:0]    program_image [PROG_DEPTH_DEF];
	int                   n_items = 0;
	int                   rx_stall = 0;
	int                   idle_cycles = 0;
	bit                   tx_calm = 1'b0;   // sender adds no random pause while set
	bit                   rx_calm = 1'b0;   // receiver starts no new stall while set

	three_bit_cpu_step u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cpu_step_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// pause length: mostly short, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver back-pressure, changed on the falling edge only
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
			m_tready <= 1'b0;
			rx_stall <= gap_len() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ends the run when neither stream moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_three_bit_cpu_step: FAIL");
				$finish;
			end
		end
	end

	// one command beat; returns right after the edge that accepted it
	task automatic send_cmd(input cmd_t kind, input logic [5:0] idx,
			input logic [WORD_W-1:0] val);
		int gap;
		gap = (!tx_calm && $urandom_range(0, 99) < 35) ? gap_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {7'd0, val, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_items++;
	endtask

	// hold the sender until every status beat is back and the block has settled
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic configure(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			input logic [DATA_W-1:0] c, input logic [LEN_W-1:0] len);
		write_reg(REG_INIT_A, a);
		write_reg(REG_INIT_B, b);
		write_reg(REG_INIT_C, c);
		write_reg(REG_PROG_LEN, DATA_W'(len));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_pair(input int slot, input logic [WORD_W-1:0] op,
			input logic [WORD_W-1:0] arg);
		program_image[2 * slot] = op;
		program_image[2 * slot + 1] = arg;
	endtask

	// every word below the program length gets written before any execute
	task automatic load_program(input int len);
		for (int i = 0; i < len; i++)
			send_cmd(CMD_LOAD, 6'(i), program_image[i]);
	endtask

	// the usual shape: hash the low bits of A, shift A down, print, loop while A != 0
	task automatic build_loop();
		set_pair(0, OP_BST, ARG_REG_A);
		set_pair(1, OP_BXL, 3'($urandom));
		set_pair(2, ($urandom_range(0, 3) == 0) ? OP_BDV : OP_CDV, ARG_REG_B);
		set_pair(3, OP_BXC, 3'($urandom));
		set_pair(4, OP_BXL, 3'($urandom));
		set_pair(5, OP_ADV, 3'($urandom_range(1, 3)));
		set_pair(6, OP_OUT, ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 6)) : ARG_REG_B);
		set_pair(7, OP_JNZ, 3'd0);
		// now and then an operand is damaged, which may hit the reserved one
		if ($urandom_range(0, 4) == 0)
			program_image[2 * $urandom_range(0, 7) + 1] = 3'($urandom);
	endtask

	// register start values: zero, all ones, full random or a few low bits
	function automatic logic [DATA_W-1:0] pick_init();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return ALL_ONES;
		if (r < 6)
			return {$urandom, $urandom};
		return {$urandom, $urandom} & ((64'd1 << $urandom_range(1, 24)) - 64'd1);
	endfunction

	// mostly executes, with loads, restarts, unused commands and full pauses mixed in
	task automatic run_steps(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				send_cmd(CMD_NOP, 6'($urandom), 3'($urandom));
			else if (r < 8)
				send_cmd(CMD_LOAD, 6'($urandom), 3'($urandom));
			else if (r < 10)
				send_cmd(CMD_RESTART, 6'($urandom), 3'($urandom));
			else if (r < 11)
				drain();
			else
				send_cmd(CMD_EXEC, 6'($urandom), 3'($urandom));
		end
	endtask

	initial begin
		int               len;
		int               steps;
		int               phase;
		bit               looped;
		logic [DATA_W-1:0] a_val;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// straight out of reset: empty program, execute only reports halted
		send_cmd(CMD_EXEC, 6'h3f, 3'd7);
		send_cmd(CMD_NOP, 6'd0, 3'd0);
		send_cmd(CMD_LOAD, 6'd63, 3'd7);
		drain();

		// A all ones walks through every opcode: b gets 7 then 0, c gets all of A,
		// b^c, a wide shift of A by itself, a faulting adv, output of c, taken jump
		configure(ALL_ONES, '0, '0, 7'd16);
		set_pair(0, OP_BST, ARG_REG_A);
		set_pair(1, OP_BXL, 3'd7);
		set_pair(2, OP_CDV, ARG_REG_B);
		set_pair(3, OP_BXC, 3'd0);
		set_pair(4, OP_BDV, ARG_REG_A);
		set_pair(5, OP_ADV, ARG_RSVD);
		set_pair(6, OP_OUT, ARG_REG_C);
		set_pair(7, OP_JNZ, 3'd0);
		load_program(16);
		send_cmd(CMD_RESTART, 6'd0, 3'd0);
		repeat (8) send_cmd(CMD_EXEC, 6'd0, 3'd0);

		// random phases: reconfigure while idle, load, restart, then run
		phase = 0;
		while (n_items < TARGET_ITEMS) begin
			drain();
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			looped = (phase > 3) && ($urandom_range(0, 9) < 6);
			if (looped) begin
				build_loop();
				len = 16;
				steps = $urandom_range(20, 160);
				a_val = ($urandom_range(0, 9) < 7) ?
					({$urandom, $urandom} & ((64'd1 << $urandom_range(1, 24)) - 64'd1)) :
					pick_init();
			end else begin
				case (phase)
					0: len = PROG_DEPTH_DEF;
					1: len = 0;
					2: len = 1;
					3: len = 2;
					default: len = $urandom_range(2, 24);
				endcase
				for (int i = 0; i < len; i++)
					program_image[i] = 3'($urandom);
				steps = (len < 3) ? 6 : $urandom_range(8, 48);
				a_val = pick_init();
			end
			configure(a_val, pick_init(), pick_init(), 7'(len));
			load_program(len);
			send_cmd(CMD_RESTART, 6'($urandom), 3'($urandom));
			run_steps(steps);
			phase++;
		end

		drain();
		if (errors == 0)
			$display("tb_three_bit_cpu_step: PASS");
		else
			$display("tb_three_bit_cpu_step: FAIL");
		$finish;
	end

endmodule
